// File: rtl/core/tcw_pkg.sv
// Shared constants for the text console writer: field widths, character
// codes and the blank cell. No dependencies.
package tcw_pkg;

  localparam int TCW_COLUMNS = 80;
  localparam int TCW_ROWS    = 25;

  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;
  localparam int RROW_W = 5;
  localparam int RCOL_W = 7;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'd32;
  localparam logic [ATTR_W-1:0] DEFAULT_ATTR = 8'd7;
  localparam logic [CELL_W-1:0] BLANK_CELL   = {DEFAULT_ATTR, BLANK_CODE};

  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

endpackage

// File: rtl/core/tcw_if.sv
// Valid/ready channel interfaces for the text console writer.
// Depends on tcw_pkg for the field widths.
interface tcw_in_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [CHAR_W-1:0] character;
  logic [RROW_W-1:0] read_row;
  logic [RCOL_W-1:0] read_column;

  modport source (output valid, mode, character, read_row, read_column, input ready);
  modport sink   (input valid, mode, character, read_row, read_column, output ready);
endinterface

interface tcw_out_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] cell_char;
  logic [ATTR_W-1:0] cell_attribute;
  logic [RROW_W-1:0] caret_row;
  logic [RCOL_W-1:0] caret_column;
  logic              scrolled;

  modport source (output valid, cell_char, cell_attribute, caret_row, caret_column,
                  scrolled, input ready);
  modport sink   (input valid, cell_char, cell_attribute, caret_row, caret_column,
                  scrolled, output ready);
endinterface

// File: rtl/core/text_console_writer.sv
// Text console writer top level: cursor sequencer around the screen RAM.
// Depends on tcw_pkg, tcw_in_if / tcw_out_if and tcw_ram.
//
//   channel | dir | handshake         | payload
//   --------+-----+-------------------+------------------------------------------
//   in_ch   | in  | valid/ready       | mode, character, read_row, read_column
//   out_ch  | out | valid/ready       | cell_char, cell_attribute, caret_row,
//           |     |                   | caret_column, scrolled
//
// Sequence: a put passes through accept, row base multiply, RAM access and result;
// an in-range read adds a state for the registered RAM read. A put that scrolls
// repeats the row base multiply, then blanks the recycled row, one blank write per
// cycle through the single RAM write port. One transaction is in flight at a time.
// Reset: a clearing pass writes blanks to all ROWS*COLUMNS cells, one per cycle
// (2000 cells at the defaults), with in_ch.ready low.
// Stalls: the result sits in an output register, so the next transaction is taken
// while the previous result waits; a new result waits in its last state.
module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = TCW_COLUMNS,
  parameter int ROWS    = TCW_ROWS
) (
  input  logic clk,
  input  logic rst_n,
  tcw_in_if.sink    in_ch,
  tcw_out_if.source out_ch
);

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [5:0] {
    S_INIT   = 6'b000001,
    S_IDLE   = 6'b000010,
    S_ADDR   = 6'b000100,
    S_ACCESS = 6'b001000,
    S_READ   = 6'b010000,
    S_RESP   = 6'b100000
  } state_t;

  // Control registers.
  state_t        state_r,     state_nxt;
  logic [RW-1:0] cur_row_r,   cur_row_nxt;
  logic [CW-1:0] cur_col_r,   cur_col_nxt;
  logic [RW-1:0] top_r,       top_nxt;      // physical row shown as screen row 0
  logic [AW-1:0] init_addr_r, init_addr_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Per-transaction working registers.
  logic              is_read_r,  is_read_nxt;
  logic              do_write_r, do_write_nxt;
  logic              do_read_r,  do_read_nxt;
  logic              scroll_r,   scroll_nxt;
  logic              clear_r,    clear_nxt;
  logic [CHAR_W-1:0] char_r,     char_nxt;
  logic [RW-1:0]     prow_r,     prow_nxt;
  logic [CW-1:0]     col_r,      col_nxt;
  logic [AW-1:0]     base_r,     base_nxt;
  logic [CELL_W-1:0] cell_r,     cell_nxt;

  // Output payload registers.
  logic [CHAR_W-1:0] o_char_r,   o_char_nxt;
  logic [ATTR_W-1:0] o_attr_r,   o_attr_nxt;
  logic [RROW_W-1:0] o_row_r,    o_row_nxt;
  logic [RCOL_W-1:0] o_col_r,    o_col_nxt;
  logic              o_scroll_r, o_scroll_nxt;

  // RAM ports.
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic              rd_en;
  logic [CELL_W-1:0] rd_data;

  // Shared address unit: row base plus column, used by put, read and row clear.
  logic [AW-1:0] cell_addr;
  assign cell_addr = base_r + AW'(col_r);

  logic          in_fire;
  logic          read_in_range;
  logic [RW-1:0] lrow;
  logic [RW:0]   prow_sum;
  logic [RW-1:0] prow_calc;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic          is_newline;
  logic          out_free;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign read_in_range = (int'(in_ch.read_row) < ROWS) && (int'(in_ch.read_column) < COLUMNS);
  assign is_newline    = (in_ch.character == NEWLINE_CODE);

  // Map a screen row to its physical row in the ring of rows.
  assign lrow      = (in_ch.mode == MODE_READ) ? RW'(in_ch.read_row) : cur_row_r;
  assign prow_sum  = {1'b0, top_r} + {1'b0, lrow};
  assign prow_calc = (prow_sum >= (RW+1)'(ROWS)) ? RW'(prow_sum - (RW+1)'(ROWS))
                                                 : RW'(prow_sum);

  assign col_inc = {1'b0, cur_col_r} + 1'b1;
  assign row_inc = {1'b0, cur_row_r} + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    top_nxt       = top_r;
    init_addr_nxt = init_addr_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    is_read_nxt   = is_read_r;
    do_write_nxt  = do_write_r;
    do_read_nxt   = do_read_r;
    scroll_nxt    = scroll_r;
    clear_nxt     = clear_r;
    char_nxt      = char_r;
    prow_nxt      = prow_r;
    col_nxt       = col_r;
    base_nxt      = base_r;
    cell_nxt      = cell_r;
    o_char_nxt    = o_char_r;
    o_attr_nxt    = o_attr_r;
    o_row_nxt     = o_row_r;
    o_col_nxt     = o_col_r;
    o_scroll_nxt  = o_scroll_r;
    wr_en         = 1'b0;
    wr_addr       = cell_addr;
    wr_data       = BLANK_CELL;
    rd_en         = 1'b0;

    unique case (state_r)
      S_INIT: begin
        // Sweep every cell to blank after reset.
        wr_en   = 1'b1;
        wr_addr = init_addr_r;
        if (init_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          init_addr_nxt = init_addr_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          state_nxt    = S_ADDR;
          is_read_nxt  = (in_ch.mode == MODE_READ);
          char_nxt     = in_ch.character;
          cell_nxt     = '0;
          clear_nxt    = 1'b0;
          scroll_nxt   = 1'b0;
          do_write_nxt = 1'b0;
          do_read_nxt  = 1'b0;
          prow_nxt     = prow_calc;
          if (in_ch.mode == MODE_READ) begin
            do_read_nxt = read_in_range;
            col_nxt     = CW'(in_ch.read_column);
            if (!read_in_range) begin
              prow_nxt = '0;
              col_nxt  = '0;
            end
          end else begin
            // Advance the cursor now; the write uses the old position held in
            // prow/col.
            col_nxt = cur_col_r;
            if (is_newline) begin
              cur_col_nxt = '0;
              if (row_inc == (RW+1)'(ROWS)) begin
                scroll_nxt = 1'b1;
              end else begin
                cur_row_nxt = RW'(row_inc);
              end
            end else begin
              do_write_nxt = 1'b1;
              if (col_inc == (CW+1)'(COLUMNS)) begin
                cur_col_nxt = '0;
                if (row_inc == (RW+1)'(ROWS)) begin
                  scroll_nxt = 1'b1;
                end else begin
                  cur_row_nxt = RW'(row_inc);
                end
              end else begin
                cur_col_nxt = CW'(col_inc);
              end
            end
          end
        end
      end

      S_ADDR: begin
        base_nxt  = AW'(prow_r * COLUMNS);
        state_nxt = S_ACCESS;
      end

      S_ACCESS: begin
        if (clear_r) begin
          // Blank the recycled row, one cell a cycle.
          wr_en = 1'b1;
          if (col_r == CW'(COLUMNS - 1)) begin
            state_nxt = S_RESP;
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end else if (is_read_r) begin
          rd_en     = do_read_r;
          state_nxt = do_read_r ? S_READ : S_RESP;
        end else begin
          wr_en   = do_write_r;
          wr_data = {DEFAULT_ATTR, char_r};
          if (scroll_r) begin
            // Retire the top row: it becomes the new bottom row.
            clear_nxt = 1'b1;
            prow_nxt  = top_r;
            col_nxt   = '0;
            top_nxt   = (top_r == RW'(ROWS - 1)) ? '0 : top_r + 1'b1;
            state_nxt = S_ADDR;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end

      S_READ: begin
        cell_nxt  = rd_data;
        state_nxt = S_RESP;
      end

      S_RESP: begin
        // Hold until the output register is free.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_char_nxt    = cell_r[CHAR_W-1:0];
          o_attr_nxt    = cell_r[CELL_W-1:CHAR_W];
          o_row_nxt     = RROW_W'(cur_row_r);
          o_col_nxt     = RCOL_W'(cur_col_r);
          o_scroll_nxt  = scroll_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      top_r       <= '0;
      init_addr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      top_r       <= top_nxt;
      init_addr_r <= init_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_read_r  <= is_read_nxt;
    do_write_r <= do_write_nxt;
    do_read_r  <= do_read_nxt;
    scroll_r   <= scroll_nxt;
    clear_r    <= clear_nxt;
    char_r     <= char_nxt;
    prow_r     <= prow_nxt;
    col_r      <= col_nxt;
    base_r     <= base_nxt;
    cell_r     <= cell_nxt;
    o_char_r   <= o_char_nxt;
    o_attr_r   <= o_attr_nxt;
    o_row_r    <= o_row_nxt;
    o_col_r    <= o_col_nxt;
    o_scroll_r <= o_scroll_nxt;
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_screen (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (cell_addr),
    .rd_data (rd_data)
  );

  assign out_ch.valid          = out_valid_r;
  assign out_ch.cell_char      = o_char_r;
  assign out_ch.cell_attribute = o_attr_r;
  assign out_ch.caret_row      = o_row_r;
  assign out_ch.caret_column   = o_col_r;
  assign out_ch.scrolled       = o_scroll_r;

  // Cursor and ring offset stay on the screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(cur_row_r) < ROWS) && (int'(cur_col_r) < COLUMNS) && (int'(top_r) < ROWS))
    else $error("cursor or top row out of range");

  // A read transaction never writes the screen.
  a_read_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACCESS && is_read_r) |-> !wr_en)
    else $error("write during read transaction");

  // An accepted transaction starts at the address stage.
  a_accept_addr: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_ADDR))
    else $error("accepted transaction did not enter address stage");

  // The ring offset moves only when a scrolling put retires its top row.
  a_top_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (top_r != $past(top_r)) |-> ($past(state_r) == S_ACCESS && $past(scroll_r)
                                  && !$past(clear_r) && !$past(is_read_r)))
    else $error("top row moved outside a scroll");

  // Results come out only from the response state.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_RESP))
    else $error("result loaded outside response state");

endmodule

// File: rtl/core/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: verif/testbench.sv
// Testbench for text_console_writer: random and directed put/read transactions
// checked against a cell-accurate shadow of the screen and cursor.
// Depends on tcw_pkg, tcw_in_if / tcw_out_if and the text_console_writer RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tcw_pkg::*;

  localparam int SCREEN_ROWS  = TCW_ROWS;
  localparam int SCREEN_COLS  = TCW_COLUMNS;
  localparam int ITEM_TARGET  = 1650;  // no new burst once this many are accepted
  localparam int MAX_IDLE     = 16;    // longest per-transaction gap on either side
  localparam int HOLD_AFTER   = 300;   // results before the long output hold-off
  localparam int HOLD_CYCLES  = 600;   // length of that hold-off
  localparam int DRAIN_CYCLES = 120;   // covers a scroll plus the read latency

  // One request on in_ch and one response on out_ch, at the block's widths.
  typedef struct packed {
    logic              mode;
    logic [CHAR_W-1:0] character;
    logic [RROW_W-1:0] read_row;
    logic [RCOL_W-1:0] read_column;
  } console_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic [ATTR_W-1:0] cell_attribute;
    logic [RROW_W-1:0] caret_row;
    logic [RCOL_W-1:0] caret_column;
    logic              scrolled;
  } console_resp_t;

  // Shapes of random stimulus; text-like bursts dominate by length.
  typedef enum int {
    BURST_TEXT, BURST_WRAP, BURST_NEWLINES, BURST_PROBE, BURST_CONTROL, BURST_NOISE
  } burst_t;

  // Shadow of the screen store and cursor. Every accepted request is applied
  // here and its response queued; every accepted response is popped and compared.
  class console_shadow;
    logic [CELL_W-1:0] cells [SCREEN_ROWS][SCREEN_COLS];
    int unsigned       row_pos;
    int unsigned       col_pos;
    console_resp_t     expected_q[$];
    int unsigned       mismatches;

    function new();
      foreach (cells[r, c]) cells[r][c] = BLANK_CELL;
      row_pos    = 0;
      col_pos    = 0;
      mismatches = 0;
    endfunction

    function void note_request(console_req_t req);
      console_resp_t want;
      want = '0;
      if (req.mode == MODE_READ) begin
        // Reads outside the grid return an empty cell.
        if (int'(req.read_row) < SCREEN_ROWS && int'(req.read_column) < SCREEN_COLS) begin
          {want.cell_attribute, want.cell_char} = cells[req.read_row][req.read_column];
        end
      end else begin
        if (req.character == NEWLINE_CODE) begin
          row_pos++;
          col_pos = 0;
        end else begin
          cells[row_pos][col_pos] = {DEFAULT_ATTR, req.character};
          col_pos++;
        end
        if (col_pos >= SCREEN_COLS) begin
          col_pos = 0;
          row_pos++;
        end
        if (row_pos >= SCREEN_ROWS) begin
          for (int line = 0; line < SCREEN_ROWS - 1; line++) cells[line] = cells[line + 1];
          for (int c = 0; c < SCREEN_COLS; c++) cells[SCREEN_ROWS - 1][c] = BLANK_CELL;
          row_pos       = SCREEN_ROWS - 1;
          want.scrolled = 1'b1;
        end
      end
      want.caret_row    = RROW_W'(row_pos);
      want.caret_column = RCOL_W'(col_pos);
      expected_q.push_back(want);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s expected %0d got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_response(console_resp_t got);
      console_resp_t want;
      if (expected_q.size() == 0) begin
        $error("response with no transaction outstanding (cursor %0d,%0d)",
               got.caret_row, got.caret_column);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("cell_char", 32'(want.cell_char), 32'(got.cell_char));
      compare_field("cell_attribute", 32'(want.cell_attribute), 32'(got.cell_attribute));
      compare_field("caret_row", 32'(want.caret_row), 32'(got.caret_row));
      compare_field("caret_column", 32'(want.caret_column), 32'(got.caret_column));
      compare_field("scrolled", 32'(want.scrolled), 32'(got.scrolled));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  tcw_in_if  in_ch();
  tcw_out_if out_ch();

  text_console_writer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  console_shadow shadow = new();

  bit          sender_idles = 1'b1;  // per-burst: draw gaps or offer back to back
  bit          sink_idles   = 1'b1;  // toggled now and then by the response side
  bit          hold_off     = 1'b0;  // long output stall, timed by its own process
  int unsigned sent_count   = 0;
  int unsigned results_seen = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Put request: the read fields carry junk, which the block must ignore.
  function automatic console_req_t put_req(logic [CHAR_W-1:0] ch);
    console_req_t req;
    req.mode        = MODE_PUT;
    req.character   = ch;
    req.read_row    = RROW_W'($urandom_range(0, (1 << RROW_W) - 1));
    req.read_column = RCOL_W'($urandom_range(0, (1 << RCOL_W) - 1));
    return req;
  endfunction

  // Read request: the character field carries junk.
  function automatic console_req_t read_req(int unsigned row, int unsigned col);
    console_req_t req;
    req.mode        = MODE_READ;
    req.character   = CHAR_W'($urandom_range(0, 255));
    req.read_row    = RROW_W'(row);
    req.read_column = RCOL_W'(col);
    return req;
  endfunction

  // Every field drawn over its whole width, out-of-range reads included.
  function automatic console_req_t random_req();
    console_req_t req;
    req.mode        = 1'($urandom_range(0, 1));
    req.character   = CHAR_W'($urandom_range(0, 255));
    req.read_row    = RROW_W'($urandom_range(0, (1 << RROW_W) - 1));
    req.read_column = RCOL_W'($urandom_range(0, (1 << RCOL_W) - 1));
    return req;
  endfunction

  // Offer one request and hold it until the block takes it. Keep valid high
  // across back-to-back transactions; drop it only when a gap is drawn.
  task automatic send_request(input console_req_t req);
    int unsigned gap;
    gap = sender_idles ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= req.mode;
    in_ch.character   <= req.character;
    in_ch.read_row    <= req.read_row;
    in_ch.read_column <= req.read_column;
    do @(posedge clk); while (!in_ch.ready);
    shadow.note_request(req);
    sent_count++;
  endtask

  // Stimulus: reset, a directed pass over edge cases, then random bursts.
  initial begin : stimulus
    burst_t                kind;
    int unsigned           n;
    logic [CHAR_W-1:0]     ch;
    int unsigned           row;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.mode        <= MODE_PUT;
    in_ch.character   <= '0;
    in_ch.read_row    <= '0;
    in_ch.read_column <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Blank screen after the clearing pass: corners, then reads off the grid.
    send_request(read_req(0, 0));
    send_request(read_req(SCREEN_ROWS - 1, SCREEN_COLS - 1));
    send_request(read_req(SCREEN_ROWS, 0));
    send_request(read_req(0, SCREEN_COLS));
    send_request(read_req((1 << RROW_W) - 1, (1 << RCOL_W) - 1));
    // Extreme and control bytes are stored as glyphs, not interpreted.
    send_request(put_req(8'h00));
    send_request(put_req(8'hFF));
    send_request(put_req(8'h41));
    send_request(put_req(8'h0D));
    send_request(put_req(8'h09));
    send_request(put_req(8'h08));
    send_request(read_req(0, 0));
    send_request(read_req(0, 1));
    send_request(read_req(0, 4));
    send_request(read_req(0, 5));
    // Newline moves to the next row, column zero, and writes nothing.
    send_request(put_req(NEWLINE_CODE));
    send_request(put_req(NEWLINE_CODE));
    send_request(put_req(8'h7F));
    send_request(read_req(2, 0));
    send_request(read_req(1, 0));
    send_request(read_req(0, 6));

    // Random bursts: mostly text with newlines, long lines that wrap and
    // newline runs that push the cursor off the bottom, mixed with read probes
    // and fully random noise.
    while (sent_count < ITEM_TARGET) begin
      sender_idles = ($urandom_range(0, 3) != 0);
      kind         = burst_t'($urandom_range(0, BURST_NOISE));
      case (kind)
        BURST_TEXT: begin
          n = $urandom_range(8, 60);
          repeat (n) begin
            ch = ($urandom_range(0, 11) == 0) ? NEWLINE_CODE
                                                : CHAR_W'($urandom_range(32, 126));
            send_request(put_req(ch));
          end
        end
        BURST_WRAP: begin
          n = $urandom_range(SCREEN_COLS, 2 * SCREEN_COLS + 10);
          repeat (n) begin
            ch = CHAR_W'($urandom_range(0, 255));
            if (ch == NEWLINE_CODE) ch = BLANK_CODE;
            send_request(put_req(ch));
          end
        end
        BURST_NEWLINES: begin
          n = $urandom_range(1, 30);
          repeat (n) send_request(put_req(NEWLINE_CODE));
        end
        BURST_PROBE: begin
          n = $urandom_range(2, 20);
          repeat (n) begin
            // Favor the row being written so fresh glyphs get read back.
            row = ($urandom_range(0, 1) != 0) ? shadow.row_pos
                                               : $urandom_range(0, SCREEN_ROWS - 1);
            send_request(read_req(row, $urandom_range(0, SCREEN_COLS - 1)));
          end
        end
        BURST_CONTROL: begin
          n = $urandom_range(1, 8);
          repeat (n) send_request(put_req(CHAR_W'($urandom_range(0, 31))));
        end
        default: begin
          n = $urandom_range(1, 6);
          repeat (n) send_request(random_req());
        end
      endcase
    end
    in_ch.valid <= 1'b0;

    // Drain: wait for every outstanding response, then a little longer to
    // catch any stray transaction.
    while (shadow.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Response side: draw a stall per transaction, honor the long hold-off,
  // and check every accepted response in order.
  initial begin : response_sink
    console_resp_t got;
    int unsigned   stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_idles = !sink_idles;
      stall = sink_idles ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall != 0 || hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.cell_char      = out_ch.cell_char;
      got.cell_attribute = out_ch.cell_attribute;
      got.caret_row      = out_ch.caret_row;
      got.caret_column   = out_ch.caret_column;
      got.scrolled       = out_ch.scrolled;
      shadow.check_response(got);
      results_seen++;
    end
  end

  // Back-pressure: once some traffic has flowed, hold the output off long
  // enough for the block to fill and stall its input.
  initial begin : output_hold
    do @(posedge clk); while (results_seen < HOLD_AFTER);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // Watchdog: far beyond the slowest legal run (clearing pass, every put
  // scrolling, both sides at their longest gaps).
  initial begin : watchdog
    #10ms;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_if.sv
rtl/core/tcw_ram.sv
rtl/core/text_console_writer.sv
verif/testbench.sv
